// ===== rtl/bdsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Button debounce package
// Shared payload types, register indices and reset values of the button
// debouncer with short and long press detection.
// ----------------------------------------------------------------------------
package bdsl_pkg;

   localparam int unsigned TIME_WIDTH = 32;
   localparam int unsigned CSR_WIDTH  = 16;

   typedef enum logic [0:0] {
      CSR_SETTLE_TIME = 1'b0,
      CSR_HOLD_TIME   = 1'b1
   } csr_index_type;

   localparam logic [CSR_WIDTH-1:0] SETTLE_TIME_RESET = 16'd50;
   localparam logic [CSR_WIDTH-1:0] HOLD_TIME_RESET   = 16'd1000;

   typedef struct packed {
      logic                  raw_level;
      logic [TIME_WIDTH-1:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic short_press;
      logic long_press;
      logic clean_level;
   } rsp_payload_type;

endpackage

// ===== rtl/bdsl_stream_if.sv =====
// ----------------------------------------------------------------------------
// Button debounce stream interface
// Valid and ready handshake with a typed payload; one transfer takes place
// at each rising edge at which valid and ready are both high.
// ----------------------------------------------------------------------------
interface bdsl_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (
      output valid,
      output payload,
      input  ready
   );

   modport sink (
      input  valid,
      input  payload,
      output ready
   );

endinterface

// ===== rtl/button_debounce_short_long_press_core.sv =====
// ----------------------------------------------------------------------------
// Button debounce with short and long press detection
// Debounces an active-low button sample stream and reports short and long
// presses from millisecond timestamps.
// ----------------------------------------------------------------------------
// Each request transfer carries one pin sample and its timestamp and yields
// exactly one response transfer with the debounced level and the press
// flags. A sample is captured in an input register and evaluated there when
// the state and the response register are updated; a new sample is taken
// in every cycle while the response channel does not stall. The response
// and input registers together let a sample be accepted while an earlier
// response still waits to be taken. All time differences wrap modulo 2^32.
// The user must write settle and hold times through the register port
// only while no sample is in flight; the block does not enforce this.
module button_debounce_short_long_press_core (
   input  logic                            clock,
   input  logic                            reset,
   bdsl_stream_if.sink                     req_if,
   bdsl_stream_if.source                   rsp_if,
   input  logic                            csr_write_enable,
   input  bdsl_pkg::csr_index_type         csr_index,
   input  logic [bdsl_pkg::CSR_WIDTH-1:0]  csr_write_data
);

   logic [bdsl_pkg::CSR_WIDTH-1:0]  settle_time_ff;
   logic [bdsl_pkg::CSR_WIDTH-1:0]  hold_time_ff;

   logic                            s1_valid_ff;
   bdsl_pkg::req_payload_type       s1_payload_ff;
   logic                            rsp_valid_ff;
   bdsl_pkg::rsp_payload_type       rsp_payload_ff;

   logic                            stable_level_ff, stable_level_in;
   logic                            previous_raw_ff;
   logic [bdsl_pkg::TIME_WIDTH-1:0] change_time_ff, change_time_in;
   logic [bdsl_pkg::TIME_WIDTH-1:0] press_time_ff, press_time_in;
   logic                            long_mark_ff, long_mark_in;

   logic                            advance;
   logic [bdsl_pkg::TIME_WIDTH-1:0] elapsed;
   logic [bdsl_pkg::TIME_WIDTH-1:0] held;
   logic                            settled;
   logic                            hold_reached;
   logic                            short_hit;
   logic                            long_hit;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_time_ff <= bdsl_pkg::SETTLE_TIME_RESET;
         hold_time_ff   <= bdsl_pkg::HOLD_TIME_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            bdsl_pkg::CSR_SETTLE_TIME: settle_time_ff <= csr_write_data;
            bdsl_pkg::CSR_HOLD_TIME:   hold_time_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      change_time_in  = change_time_ff;
      stable_level_in = stable_level_ff;
      press_time_in   = press_time_ff;
      long_mark_in    = long_mark_ff;
      short_hit       = 1'b0;
      long_hit        = 1'b0;

      if (s1_payload_ff.raw_level != previous_raw_ff) begin
         change_time_in = s1_payload_ff.now_ms;
      end
      elapsed      = s1_payload_ff.now_ms - change_time_in;
      held         = s1_payload_ff.now_ms - press_time_ff;
      settled      = elapsed > {{(bdsl_pkg::TIME_WIDTH-bdsl_pkg::CSR_WIDTH){1'b0}},
                                settle_time_ff};
      hold_reached = held >= {{(bdsl_pkg::TIME_WIDTH-bdsl_pkg::CSR_WIDTH){1'b0}},
                              hold_time_ff};

      if (settled) begin
         if (s1_payload_ff.raw_level != stable_level_ff) begin
            stable_level_in = s1_payload_ff.raw_level;
            if (!s1_payload_ff.raw_level) begin
               press_time_in = s1_payload_ff.now_ms;
               long_mark_in  = 1'b0;
               // A press that starts now has zero duration.
               hold_reached  = (hold_time_ff == '0);
            end else if (!long_mark_ff && !hold_reached) begin
               short_hit = 1'b1;
            end
         end
         if (!stable_level_in && !long_mark_in && hold_reached) begin
            long_mark_in = 1'b1;
         end
      end

      if (long_mark_in && stable_level_in) begin
         long_hit     = 1'b1;
         long_mark_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         stable_level_ff <= 1'b1;
         previous_raw_ff <= 1'b1;
         change_time_ff  <= '0;
         press_time_ff   <= '0;
         long_mark_ff    <= 1'b0;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_valid_ff && advance) begin
            stable_level_ff <= stable_level_in;
            previous_raw_ff <= s1_payload_ff.raw_level;
            change_time_ff  <= change_time_in;
            press_time_ff   <= press_time_in;
            long_mark_ff    <= long_mark_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_payload_ff <= req_if.payload;
      end
      if (s1_valid_ff && advance) begin
         rsp_payload_ff.short_press <= short_hit;
         rsp_payload_ff.long_press  <= long_hit;
         rsp_payload_ff.clean_level <= stable_level_in;
      end
   end

endmodule

// ===== verif/tb_button_debounce_short_long_press_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button debounce core testbench
// Drives timestamped pin samples through the request channel and predicts
// the debounced level and the short and long press flags of every sample.
// Each response transfer is compared field by field with the oldest
// prediction. Directed samples cover the settle and hold boundaries,
// timestamp wrap and zero settings. Random press gestures with chatter and
// noise samples then run under several settle and hold settings, the
// extremes among them, and all but one add random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_button_debounce_short_long_press_core;
   import bdsl_pkg::*;

   class press_event_board;
      logic [CSR_WIDTH-1:0]  settle_ms;
      logic [CSR_WIDTH-1:0]  hold_ms;
      logic                  stable_level;
      logic                  previous_raw;
      logic                  long_mark;
      logic [TIME_WIDTH-1:0] change_time;
      logic [TIME_WIDTH-1:0] press_time;
      rsp_payload_type       expected_events[$];
      int unsigned           error_count;

      function new();
         settle_ms    = SETTLE_TIME_RESET;
         hold_ms      = HOLD_TIME_RESET;
         stable_level = 1'b1;
         previous_raw = 1'b1;
         long_mark    = 1'b0;
         change_time  = '0;
         press_time   = '0;
         error_count  = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_WIDTH-1:0] value);
         if (idx == CSR_SETTLE_TIME) begin
            settle_ms = value;
         end else begin
            hold_ms = value;
         end
      endfunction

      function void note_sample(req_payload_type sample);
         rsp_payload_type       event_out;
         logic [TIME_WIDTH-1:0] elapsed;
         logic [TIME_WIDTH-1:0] held;
         event_out = '0;
         if (sample.raw_level != previous_raw) begin
            change_time = sample.now_ms;
         end
         elapsed = sample.now_ms - change_time;
         if (elapsed > {16'd0, settle_ms}) begin
            if (sample.raw_level != stable_level) begin
               stable_level = sample.raw_level;
               held = sample.now_ms - press_time;
               if (!stable_level) begin
                  press_time = sample.now_ms;
                  long_mark  = 1'b0;
               end else if (!long_mark && held < {16'd0, hold_ms}) begin
                  event_out.short_press = 1'b1;
               end
            end
            held = sample.now_ms - press_time;
            if (!stable_level && !long_mark && held >= {16'd0, hold_ms}) begin
               long_mark = 1'b1;
            end
         end
         previous_raw = sample.raw_level;
         if (long_mark && stable_level) begin
            event_out.long_press = 1'b1;
            long_mark = 1'b0;
         end
         event_out.clean_level = stable_level;
         expected_events.push_back(event_out);
      endfunction

      function void report_field(string field, logic exp_v, logic act_v);
         if (exp_v !== act_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, exp_v, act_v);
         end
      endfunction

      function void check_result(rsp_payload_type actual);
         rsp_payload_type exp_r;
         if (expected_events.size() == 0) begin
            error_count++;
            $display("%0t: response with none expected, expected nothing, actual %b",
                     $time, actual);
            return;
         end
         exp_r = expected_events.pop_front();
         report_field("short_press", exp_r.short_press, actual.short_press);
         report_field("long_press", exp_r.long_press, actual.long_press);
         report_field("clean_level", exp_r.clean_level, actual.clean_level);
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   csr_index_type        csr_index;
   logic [CSR_WIDTH-1:0] csr_write_data;

   bdsl_stream_if #(.payload_type(req_payload_type)) req_if ();
   bdsl_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   button_debounce_short_long_press_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   press_event_board      board;
   bit                    req_gaps;
   bit                    rsp_gaps;
   int unsigned           sent_items;
   logic [TIME_WIDTH-1:0] stamp;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_if.ready = !rsp_gaps || ($urandom_range(99) >= 22);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_result(rsp_if.payload);
      end
   end

   task automatic send_sample(input logic level, input logic [TIME_WIDTH-1:0] t);
      req_payload_type sample;
      while (req_gaps && $urandom_range(99) < 22) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      sample.raw_level = level;
      sample.now_ms    = t;
      req_if.valid     = 1'b1;
      req_if.payload   = sample;
      do @(posedge clock); while (!req_if.ready);
      board.note_sample(sample);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_WIDTH-1:0] value);
      req_if.valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      board.write_register(idx, value);
   endtask

   task automatic run_gesture();
      int unsigned           settle;
      int unsigned           hold;
      int unsigned           dur;
      int unsigned           chg;
      int unsigned           n;
      logic [TIME_WIDTH-1:0] press_at;
      settle = 32'(board.settle_ms);
      hold   = 32'(board.hold_ms);
      case ($urandom_range(0, 5))
         0: begin
            dur = (hold > 0) ? hold - 1 : 0;
         end
         1: begin
            dur = hold;
         end
         2: begin
            dur = hold + 1;
         end
         3: begin
            dur = $urandom_range(0, hold);
         end
         4: begin
            dur = hold + $urandom_range(1, 3 * hold + 10);
         end
         default: begin
            dur = $urandom_range(0, settle + 2);
         end
      endcase
      n = $urandom_range(0, 3);
      repeat (n) begin
         stamp += $urandom_range(0, 3);
         send_sample(1'($urandom_range(0, 1)), stamp);
      end
      stamp += $urandom_range(0, 20);
      send_sample(1'b0, stamp);
      stamp += settle + 1 + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
      send_sample(1'b0, stamp);
      press_at = stamp;
      chg = (dur > settle + 1) ? dur - settle - 1 : 0;
      n = $urandom_range(0, 3);
      repeat (n) begin
         stamp += chg / 4;
         send_sample(1'b0, stamp);
      end
      if ($urandom_range(0, 2) == 0) begin
         send_sample(1'b1, stamp);
         send_sample(1'b0, stamp);
      end
      stamp = press_at + chg;
      send_sample(1'b1, stamp);
      stamp += settle + 1;
      send_sample(1'b1, stamp);
      n = $urandom_range(0, 2);
      repeat (n) begin
         stamp += $urandom_range(0, 2 * settle + 2);
         send_sample(1'b1, stamp);
      end
   endtask

   initial begin
      logic [CSR_WIDTH-1:0] settle_list[6];
      logic [CSR_WIDTH-1:0] hold_list[6];
      int unsigned          goal;
      board            = new();
      req_gaps         = 1'b1;
      rsp_gaps         = 1'b1;
      sent_items       = 0;
      stamp            = '0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SETTLE_TIME;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      send_sample(1'b1, 32'd0);
      send_sample(1'b0, 32'd100);
      send_sample(1'b0, 32'd150);
      send_sample(1'b0, 32'd151);
      send_sample(1'b1, 32'd200);
      send_sample(1'b1, 32'd251);
      send_sample(1'b0, 32'd300);
      send_sample(1'b0, 32'd351);
      send_sample(1'b0, 32'd1350);
      send_sample(1'b0, 32'd1351);
      send_sample(1'b1, 32'd1400);
      send_sample(1'b1, 32'd1451);
      send_sample(1'b0, 32'd2000);
      send_sample(1'b0, 32'd2051);
      send_sample(1'b1, 32'd3000);
      send_sample(1'b1, 32'd3050);
      send_sample(1'b0, 32'hFFFF_FFF0);
      send_sample(1'b0, 32'h0000_0023);
      send_sample(1'b1, 32'h0000_0040);
      send_sample(1'b1, 32'h0000_0073);
      send_sample(1'b1, 32'h0000_0010);
      write_register(CSR_SETTLE_TIME, 16'd0);
      write_register(CSR_HOLD_TIME, 16'd0);
      send_sample(1'b0, 32'd5);
      send_sample(1'b0, 32'd6);
      send_sample(1'b1, 32'd7);
      send_sample(1'b1, 32'd8);

      settle_list = '{16'd50, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
      hold_list   = '{16'd1000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
      settle_list[5] = 16'($urandom_range(0, 30));
      hold_list[5]   = 16'($urandom_range(1, 400));
      goal = sent_items;
      for (int phase = 0; phase < 6; phase++) begin
         write_register(CSR_SETTLE_TIME, settle_list[phase]);
         write_register(CSR_HOLD_TIME, hold_list[phase]);
         req_gaps = (phase != 2);
         rsp_gaps = (phase != 2);
         stamp = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 5000);
         goal += 200;
         while (sent_items < goal) begin
            if ($urandom_range(0, 9) == 0) begin
               send_sample(1'($urandom_range(0, 1)), $urandom);
            end else begin
               run_gesture();
            end
         end
      end

      req_if.valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bdsl_pkg.sv
rtl/bdsl_stream_if.sv
rtl/button_debounce_short_long_press_core.sv
verif/tb_button_debounce_short_long_press_core.sv
